FILE: rtl/sha1_pkg.sv
// SHA-1 engine package: item types, controller command struct, round constants
// and the padding helper used by the datapath.
// No dependencies.
package sha1_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CountW  = 3;
  localparam int unsigned PosW    = 4;   // 16-word block
  localparam int unsigned RoundW  = 7;   // 80 rounds
  localparam int unsigned LenW    = 64;

  localparam logic [RoundW-1:0] LAST_ROUND  = 7'd79;
  localparam logic [RoundW-1:0] SCHED_LOAD  = 7'd16;
  localparam logic [RoundW-1:0] PHASE1_FROM = 7'd20;
  localparam logic [RoundW-1:0] PHASE2_FROM = 7'd40;
  localparam logic [RoundW-1:0] PHASE3_FROM = 7'd60;
  localparam logic [PosW-1:0]   POS_LEN_HI  = 4'd14;
  localparam logic [PosW-1:0]   POS_LAST    = 4'd15;
  localparam logic [CountW-1:0] FULL_COUNT  = 3'd4;

  localparam logic [WordW-1:0] ROUND_K [4] = '{
    32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
  };
  localparam logic [WordW-1:0] INIT_H [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };
  localparam logic [WordW-1:0] ONE_BIT_WORD = 32'h8000_0000;

  typedef struct packed {
    logic [WordW-1:0]  data_word;
    logic [CountW-1:0] byte_count;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word0;
    logic [WordW-1:0] digest_word1;
    logic [WordW-1:0] digest_word2;
    logic [WordW-1:0] digest_word3;
    logic [WordW-1:0] digest_word4;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_DONE
  } state_t;

  // Source of a word shifted into the schedule window
  typedef enum logic [2:0] {
    PUSH_DATA,
    PUSH_TAIL,    // partial last word with its marker bit
    PUSH_ONE,
    PUSH_ZERO,
    PUSH_LEN_HI,
    PUSH_LEN_LO
  } push_sel_t;

  typedef struct packed {
    logic              push;
    push_sel_t         push_sel;
    logic              len_add;
    logic              load_work;
    logic              round;
    logic [RoundW-1:0] rnd;
    logic              add;
    logic              emit;
  } cmd_t;

  function automatic logic [CountW-1:0] clamp_count(input logic [CountW-1:0] c);
    return (c > FULL_COUNT) ? FULL_COUNT : c;
  endfunction

  // Keep the leading valid bytes and append the 1 bit right after them; a full word passes unchanged
  function automatic logic [WordW-1:0] tail_word(input logic [WordW-1:0] d,
                                                 input logic [CountW-1:0] c);
    logic [WordW-1:0] w;
    case (c)
      3'd0:    w = 32'h8000_0000;
      3'd1:    w = {d[31:24], 24'h80_0000};
      3'd2:    w = {d[31:16], 16'h8000};
      3'd3:    w = {d[31:8], 8'h80};
      default: w = d;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/sha1_hash_engine_core.sv
// SHA-1 hash engine top level: joins controller and datapath.
// Depends on sha1_pkg, sha1_ctrl, sha1_dpath.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_ready  | in_item  (data_word, byte_count, last)
//   out     | out_valid / out_ready| out_item (digest_word0..digest_word4)
//
// Mid-block words are taken one per cycle while in_ready is high; the sixteenth starts
// 80 rounds (one per cycle) and then a fold into the chaining value (ST_ADD).
// A last word adds a push per padding word (one or two blocks) and a digest
// load; in_ready stays low through all of it.
// Reset (rst, synchronous) restores the initial chaining value, zero length.
// The digest register buffers one item; only loading a second one waits for out_ready.
module sha1_hash_engine_core
  import sha1_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  cmd_t cmd;

  sha1_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  sha1_dpath u_dpath (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .out_item (out_item)
  );

`ifndef SYNTHESIS
  // A digest only appears after the controller loaded the digest register
  a_emit_before_valid: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.emit))
    else $error("out_valid rose without a digest load");

  // Compression always begins at round zero right after the working load
  a_load_then_round0: assert property (@(posedge clk) disable iff (rst)
    cmd.load_work |=> (cmd.round && cmd.rnd == '0))
    else $error("compression did not start at round zero");

  // The final round is followed by the chaining-value update
  a_last_round_add: assert property (@(posedge clk) disable iff (rst)
    (cmd.round && cmd.rnd == LAST_ROUND) |=> cmd.add)
    else $error("missing chaining update after last round");
`endif

endmodule

FILE: rtl/sha1_ctrl.sv
// SHA-1 controller: input/output handshake, block word position, padding
// sequence and round counter. Drives the datapath through cmd_t (sha1_pkg).
module sha1_ctrl
  import sha1_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_item_t in_item,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output cmd_t     cmd
);

  state_t            state, state_next;
  logic [PosW-1:0]   pos, pos_next;
  logic [RoundW-1:0] rnd, rnd_next;
  logic              padding, padding_next;
  logic              need_one, need_one_next;
  logic              hi_done, hi_done_next;
  logic              final_blk, final_blk_next;
  logic [CountW-1:0] cnt;
  logic              accept;
  logic              pushed;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      rnd       <= '0;
      padding   <= 1'b0;
      need_one  <= 1'b0;
      hi_done   <= 1'b0;
      final_blk <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      rnd       <= rnd_next;
      padding   <= padding_next;
      need_one  <= need_one_next;
      hi_done   <= hi_done_next;
      final_blk <= final_blk_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign cnt      = clamp_count(in_item.byte_count);

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    rnd_next       = rnd;
    padding_next   = padding;
    need_one_next  = need_one;
    hi_done_next   = hi_done;
    final_blk_next = final_blk;
    cmd            = '0;
    cmd.push_sel   = PUSH_ZERO;
    cmd.rnd        = rnd;
    pushed         = 1'b0;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!in_item.last) begin
            if (cnt != '0) begin
              cmd.push     = 1'b1;
              cmd.push_sel = PUSH_DATA;
              cmd.len_add  = 1'b1;
              pushed       = 1'b1;
            end
          end else begin
            cmd.push      = 1'b1;
            cmd.len_add   = 1'b1;
            pushed        = 1'b1;
            padding_next  = 1'b1;
            need_one_next = (cnt == FULL_COUNT);
            cmd.push_sel  = (cnt == FULL_COUNT) ? PUSH_DATA : PUSH_TAIL;
          end
        end
      end

      ST_PAD: begin
        cmd.push = 1'b1;
        pushed   = 1'b1;
        if (need_one) begin
          cmd.push_sel  = PUSH_ONE;
          need_one_next = 1'b0;
        end else if (pos == POS_LEN_HI) begin
          cmd.push_sel = PUSH_LEN_HI;
          hi_done_next = 1'b1;
        end else if (pos == POS_LAST && hi_done) begin
          cmd.push_sel   = PUSH_LEN_LO;
          final_blk_next = 1'b1;
        end else begin
          cmd.push_sel = PUSH_ZERO;
        end
      end

      ST_ROUND: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 1'b1;
        if (rnd == LAST_ROUND) begin
          state_next = ST_ADD;
        end
      end

      ST_ADD: begin
        cmd.add = 1'b1;
        if (final_blk) begin
          state_next = ST_DONE;
        end else if (padding) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end

      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          padding_next   = 1'b0;
          hi_done_next   = 1'b0;
          final_blk_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Every push advances the block position; the sixteenth starts a compression
    if (pushed) begin
      pos_next = pos + 1'b1;
      if (pos == POS_LAST) begin
        cmd.load_work = 1'b1;
        rnd_next      = '0;
        state_next    = ST_ROUND;
      end else if (padding_next) begin
        state_next = ST_PAD;
      end
    end
  end

endmodule

FILE: rtl/sha1_dpath.sv
// SHA-1 datapath: chaining value, working variables, 16-word schedule shift
// window, bit-length counter and digest register. Uses sha1_pkg.
module sha1_dpath
  import sha1_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output out_item_t out_item
);

  logic [WordW-1:0] chain [5];
  logic [WordW-1:0] work  [5];
  logic [WordW-1:0] sched [16];
  logic [LenW-1:0]  bit_len;

  logic [WordW-1:0]  push_word;
  logic [WordW-1:0]  w_new, w_t, f, k, t_sum;
  logic [WordW-1:0]  a, b, c, d, e;
  logic [CountW-1:0] cnt;
  logic [LenW-1:0]   len_inc;

  assign a   = work[0];
  assign b   = work[1];
  assign c   = work[2];
  assign d   = work[3];
  assign e   = work[4];
  assign cnt = clamp_count(in_item.byte_count);

  always_comb begin
    case (cmd.push_sel)
      PUSH_DATA:   push_word = in_item.data_word;
      PUSH_TAIL:   push_word = tail_word(in_item.data_word, cnt);
      PUSH_ONE:    push_word = ONE_BIT_WORD;
      PUSH_LEN_HI: push_word = bit_len[63:32];
      PUSH_LEN_LO: push_word = bit_len[31:0];
      default:     push_word = '0;
    endcase
    len_inc = in_item.last ? LenW'({cnt, 3'b000}) : LenW'(WordW);
  end

  // Window holds W[t..15] then W[0..t-1] before the schedule is expanded, W[t-16..t-1] after
  always_comb begin
    w_new = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
    w_new = {w_new[30:0], w_new[31]};
    w_t   = (cmd.rnd < SCHED_LOAD) ? sched[0] : w_new;
    if (cmd.rnd < PHASE1_FROM) begin
      f = (b & c) | (~b & d);
      k = ROUND_K[0];
    end else if (cmd.rnd < PHASE2_FROM) begin
      f = b ^ c ^ d;
      k = ROUND_K[1];
    end else if (cmd.rnd < PHASE3_FROM) begin
      f = (b & c) | (b & d) | (c & d);
      k = ROUND_K[2];
    end else begin
      f = b ^ c ^ d;
      k = ROUND_K[3];
    end
    t_sum = {a[26:0], a[31:27]} + f + e + k + w_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_len <= '0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= INIT_H[i];
      end
    end else begin
      if (cmd.emit) begin
        bit_len <= '0;
      end else if (cmd.len_add) begin
        bit_len <= bit_len + len_inc;
      end
      if (cmd.emit) begin
        for (int i = 0; i < 5; i++) begin
          chain[i] <= INIT_H[i];
        end
      end else if (cmd.add) begin
        for (int i = 0; i < 5; i++) begin
          chain[i] <= chain[i] + work[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push || cmd.round) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[15] <= cmd.push ? push_word : w_t;
    end
    if (cmd.load_work) begin
      for (int i = 0; i < 5; i++) begin
        work[i] <= chain[i];
      end
    end else if (cmd.round) begin
      work[0] <= t_sum;
      work[1] <= a;
      work[2] <= {b[1:0], b[31:2]};
      work[3] <= c;
      work[4] <= d;
    end
    if (cmd.emit) begin
      out_item <= '{chain[0], chain[1], chain[2], chain[3], chain[4]};
    end
  end

endmodule

FILE: sim/sha1_hash_engine_core_tb.sv
// Self-checking testbench for sha1_hash_engine_core: streams messages as word items
// and checks every digest against an in-bench SHA-1 model with its own padding.
// Depends on sha1_pkg (item types) and the RTL of sha1_hash_engine_core.
module sha1_hash_engine_core_tb
  import sha1_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int TAIL_CYCLES  = 400;    // > two padded blocks of rounds
  localparam int RAND_WORDS   = 950;
  localparam int STALL_AT     = 300;    // words accepted before the long out stall
  localparam int STALL_LEN    = 1500;
  localparam int CALM_FROM    = 500;    // no idling on either side in this window
  localparam int CALM_TO      = 750;
  localparam int MAX_PRINTS   = 40;

  // Own copy of the FIPS 180-4 constants, kept apart from the package
  localparam logic [31:0] K_TAB [4] = '{
    32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
  };
  localparam logic [31:0] H_INIT [5] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };
  localparam logic [31:0] MARK_WORD = 32'h8000_0000;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  sha1_hash_engine_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Hash model: chaining value, 16-word window, bit count, fill position
  // ---------------------------------------------------------------------------
  logic [31:0] chain_h [5];
  logic [31:0] sched_w [16];
  logic [63:0] msg_bits;
  int          wpos;

  in_item_t    msg_word_q [$];   // items waiting for the driver
  out_item_t   digest_q   [$];   // digests still owed by the block
  int          words_taken = 0;  // accepted input items
  int          cycle_cnt   = 0;
  int          err_cnt     = 0;
  int          rand_words  = 0;
  logic        calm;

  assign calm = (words_taken >= CALM_FROM) && (words_taken < CALM_TO);

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_hash();
    chain_h  = H_INIT;
    msg_bits = '0;
    wpos     = 0;
  endfunction

  // 80 rounds over the current window, folded into the chaining value
  function automatic void crunch_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, t;
    w = sched_w;
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w[r & 15] = rol(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
      end else if (r < 40 || r >= 60) begin
        f = b ^ c ^ d;
      end else begin
        f = (b & c) | (b & d) | (c & d);
      end
      t = rol(a, 5) + f + e + K_TAB[r / 20] + w[r & 15];
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d; chain_h[4] += e;
  endfunction

  function automatic void shift_in(input logic [31:0] x);
    sched_w[wpos] = x;
    wpos = (wpos + 1) & 15;
    if (wpos == 0) crunch_block();
  endfunction

  // Apply one accepted item; a last item closes the message and owes a digest
  function automatic void absorb_item(input in_item_t it);
    int          n;
    logic [31:0] keep;
    out_item_t   dg;
    n = (it.byte_count > 3'd4) ? 4 : int'(it.byte_count);
    if (!it.last) begin
      if (n == 0) return;               // empty mid-message word: ignored
      msg_bits += 64'd32;               // short mid-message word counts as full
      shift_in(it.data_word);
      return;
    end
    msg_bits += 64'(8 * n);
    if (n == 4) begin
      shift_in(it.data_word);
      shift_in(MARK_WORD);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * n));
      shift_in((it.data_word & keep) | (32'h80 << (24 - 8 * n)));
    end
    // no room for the length in this block: pad it out and start another
    if (wpos > 14) begin
      while (wpos != 0) shift_in(32'h0);
    end
    while (wpos < 14) shift_in(32'h0);
    shift_in(msg_bits[63:32]);
    shift_in(msg_bits[31:0]);
    dg = '{chain_h[0], chain_h[1], chain_h[2], chain_h[3], chain_h[4]};
    digest_q.push_back(dg);
    restart_hash();
  endfunction

  task automatic flag_mismatch(input string what);
    if (err_cnt < MAX_PRINTS) $display("[%0t] MISMATCH %s", $realtime, what);
    err_cnt++;
  endtask

  task automatic check_digest(input out_item_t got);
    out_item_t   want;
    logic [31:0] g [5];
    logic [31:0] x [5];
    if (digest_q.size() == 0) begin
      flag_mismatch($sformatf("digest %h with none expected", got));
      return;
    end
    want = digest_q.pop_front();
    g = '{got.digest_word0, got.digest_word1, got.digest_word2, got.digest_word3,
          got.digest_word4};
    x = '{want.digest_word0, want.digest_word1, want.digest_word2, want.digest_word3,
          want.digest_word4};
    for (int i = 0; i < 5; i++) begin
      if (g[i] !== x[i]) flag_mismatch($sformatf("digest_word%0d got %h exp %h", i, g[i], x[i]));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void queue_item(input logic [31:0] d, input logic [2:0] n,
                                     input logic lst);
    in_item_t it;
    it.data_word  = d;
    it.byte_count = n;
    it.last       = lst;
    msg_word_q.push_back(it);
  endfunction

  // One random message: mostly full words, some short or over-range counts
  // mid-message, the odd ignorable empty word, and a last word of any count.
  function automatic void queue_message(input int nwords);
    logic [2:0] n;
    for (int i = 0; i < nwords; i++) begin
      if ($urandom_range(0, 99) < 5) queue_item($urandom, 3'd0, 1'b0);   // noise
      n = ($urandom_range(0, 99) < 80) ? 3'd4 : 3'($urandom_range(1, 7));
      queue_item($urandom, n, 1'b0);
      rand_words++;
    end
    queue_item($urandom, 3'($urandom_range(0, 7)), 1'b1);
    rand_words++;
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    // short messages dominate so the padding boundary moves around a lot
    if (r < 70) return $urandom_range(0, 17);
    if (r < 90) return $urandom_range(18, 40);
    return $urandom_range(41, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items; valid holds until the item is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_p
    logic fire;
    logic gap;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        absorb_item(in_item);
        words_taken <= words_taken + 1;
      end
      if (!in_valid || fire) begin
        gap = !calm && ($urandom_range(0, 99) < 9);
        if (msg_word_q.size() != 0 && !gap) begin
          in_valid <= 1'b1;
          in_item  <= msg_word_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks digests, drives out_ready with random stalls and one
  // long hold-off that backs the block up into its input
  // ---------------------------------------------------------------------------
  int   stall_left = 0;
  logic stall_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      stall_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_digest(out_item);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (!stall_done && words_taken >= STALL_AT) begin
        stall_left <= STALL_LEN;
        stall_done <= 1'b1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sha1_hash_engine_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed items, random messages, reset, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    restart_hash();
    // empty message
    queue_item(32'h0000_0000, 3'd0, 1'b1);
    // three-byte message with junk in the unused byte
    queue_item(32'h6162_63FF, 3'd3, 1'b1);
    // over-range count on a last word acts as four
    queue_item(32'hFFFF_FFFF, 3'd7, 1'b1);
    // short mid-message word, ignored empty word, empty last word
    queue_item(32'h1234_5678, 3'd2, 1'b0);
    queue_item(32'hDEAD_BEEF, 3'd0, 1'b0);
    queue_item(32'hFFFF_FFFF, 3'd0, 1'b1);
    // full last word of zeros
    queue_item(32'h0000_0000, 3'd4, 1'b1);
    // one-byte and two-byte tails with junk past the count, after over-range mid words
    queue_item(32'hA5FF_FFFF, 3'd1, 1'b1);
    queue_item(32'hFFFF_0000, 3'd5, 1'b0);
    queue_item(32'h0F0F_FFFF, 3'd2, 1'b1);
    queue_item(32'hFFFF_FFFF, 3'd6, 1'b0);
    queue_item(32'h0000_0000, 3'd1, 1'b1);

    while (rand_words < RAND_WORDS) queue_message(pick_length());

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // all items taken, then all digests back, then a quiet tail
    while (msg_word_q.size() != 0 || in_valid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("sha1_hash_engine_core test passed");
    end else begin
      $display("sha1_hash_engine_core test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sha1_pkg.sv
rtl/sha1_ctrl.sv
rtl/sha1_dpath.sv
rtl/sha1_hash_engine_core.sv
sim/sha1_hash_engine_core_tb.sv
